// ===== hw/rtl/vrpc_pkg.sv =====
// shared types and constants of the voronoi region point classifier
package vrpc_pkg;

	localparam int KIND_W     = 2;
	localparam int SLOT_W     = 4;
	localparam int FIELD_W    = 32;
	localparam int TAG_W      = 16;
	localparam int COUNT_W    = 5;
	localparam int RADIUS_W   = 31;
	localparam int RSQ_W      = 2 * RADIUS_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// input tdata layout, lowest bit first
	localparam int SLOT_LSB   = 0;
	localparam int X_LSB      = SLOT_LSB + SLOT_W;
	localparam int Y_LSB      = X_LSB + FIELD_W;
	localparam int Z_LSB      = Y_LSB + FIELD_W;
	localparam int TAG_LSB    = Z_LSB + FIELD_W;
	localparam int IN_DATA_W  = ((TAG_LSB + TAG_W + 7) / 8) * 8;

	// output tdata layout, lowest bit first
	localparam int OUT_BITS   = 1 + TAG_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [KIND_W-1:0] KIND_LOAD_ATTR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_REP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLASSIFY  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ATTR_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REP_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd3;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic valid;
		logic sel_rep;
		logic first;
	} dist_tag_t;

endpackage

// ===== hw/rtl/vrpc_cell.sv =====
// one site cell of the rotating site chain
module vrpc_cell #(
	parameter int COORD_BITS = 32
) (
	input  logic                          clk,
	input  vrpc_pkg::cell_ctrl_t          ctrl,
	input  logic signed [COORD_BITS-1:0]  load_x,
	input  logic signed [COORD_BITS-1:0]  load_y,
	input  logic signed [COORD_BITS-1:0]  load_z,
	input  logic signed [COORD_BITS-1:0]  next_x,
	input  logic signed [COORD_BITS-1:0]  next_y,
	input  logic signed [COORD_BITS-1:0]  next_z,
	output logic signed [COORD_BITS-1:0]  site_x,
	output logic signed [COORD_BITS-1:0]  site_y,
	output logic signed [COORD_BITS-1:0]  site_z
);

	logic signed [COORD_BITS-1:0] x_q, y_q, z_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= load_x;
			y_q <= load_y;
			z_q <= load_z;
		end else if (ctrl.shift) begin
			x_q <= next_x;
			y_q <= next_y;
			z_q <= next_z;
		end
	end

	assign site_x = x_q;
	assign site_y = y_q;
	assign site_z = z_q;

endmodule

// ===== hw/rtl/vrpc_dist.sv =====
// pipelined squared distance unit, three stages
module vrpc_dist #(
	parameter int COORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vrpc_pkg::dist_tag_t                 tag_in,
	input  logic signed [COORD_BITS-1:0]        site_x,
	input  logic signed [COORD_BITS-1:0]        site_y,
	input  logic signed [COORD_BITS-1:0]        site_z,
	input  logic signed [COORD_BITS-1:0]        pt_x,
	input  logic signed [COORD_BITS-1:0]        pt_y,
	input  logic signed [COORD_BITS-1:0]        pt_z,
	output vrpc_pkg::dist_tag_t                 tag_out,
	output logic [2*COORD_BITS+1:0]             dist_sq
);

	localparam int PW = 2 * COORD_BITS;
	localparam int DW = PW + 2;

	logic signed [COORD_BITS:0] dx, dy, dz;
	logic signed [COORD_BITS:0] ndx, ndy, ndz;
	logic [COORD_BITS-1:0] mx_s1, my_s1, mz_s1;
	logic [PW-1:0] px_s2, py_s2, pz_s2;
	logic [DW-1:0] sum_s3;
	vrpc_pkg::dist_tag_t tag_s1, tag_s2, tag_s3;

	always_comb begin
		dx = {site_x[COORD_BITS-1], site_x} - {pt_x[COORD_BITS-1], pt_x};
		dy = {site_y[COORD_BITS-1], site_y} - {pt_y[COORD_BITS-1], pt_y};
		dz = {site_z[COORD_BITS-1], site_z} - {pt_z[COORD_BITS-1], pt_z};
		ndx = -dx;
		ndy = -dy;
		ndz = -dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1 <= dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		my_s1 <= dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		mz_s1 <= dz[COORD_BITS] ? ndz[COORD_BITS-1:0] : dz[COORD_BITS-1:0];
		px_s2 <= PW'(mx_s1) * PW'(mx_s1);
		py_s2 <= PW'(my_s1) * PW'(my_s1);
		pz_s2 <= PW'(mz_s1) * PW'(mz_s1);
		sum_s3 <= DW'(px_s2) + DW'(py_s2) + DW'(pz_s2);
	end

	assign tag_out = tag_s3;
	assign dist_sq = sum_s3;

endmodule

// ===== hw/rtl/voronoi_region_point_classifier_unit.sv =====
// top level of the voronoi region point classifier
//
//  channel  | direction | signals                                  | beat
//  s_axis   | in        | tvalid tready tdata[119:0] tuser[1:0]    | load or classify item
//  m_axis   | out       | tvalid tready tdata[23:0]                | classification result
//  cfg      | in        | valid ready index[1:0] data[30:0]        | register write
//
//  a load beat leaves the block idle and ready; a classify beat keeps it busy while the
//  single distance pipeline sees each site once as the two site chains rotate past it
//  reset clears counts to one, radius mode and radius to zero; site tables hold no reset value
//  a stalled m_axis holds the result and the block still takes the next beat;
//  a second result waits until the first is taken
module voronoi_region_point_classifier_unit #(
	parameter int MAX_SITES  = 16,
	parameter int COORD_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// slot[3:0], point_x[35:4], point_y[67:36], point_z[99:68], point_tag[115:100], zero
	input  logic [vrpc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// kind[1:0]
	input  logic [vrpc_pkg::KIND_W-1:0]           s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// inside_res[0], result_tag[16:1], zero
	output logic [vrpc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vrpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [vrpc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CNT_W = $clog2(MAX_SITES + 1);
	localparam int DW    = 2 * COORD_BITS + 2;
	localparam int CMP_W = (DW > vrpc_pkg::RSQ_W) ? DW : vrpc_pkg::RSQ_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN_A = 3'd1;
	localparam logic [2:0] ST_RUN_R = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	localparam logic [1:0] DRAIN_LAST = 2'd2;

	logic [2:0] state_q;
	logic [CNT_W-1:0] idx_q;
	logic [1:0] drain_q;

	logic [vrpc_pkg::COUNT_W-1:0] attr_cnt_q, rep_cnt_q;
	logic radius_mode_q;
	logic [vrpc_pkg::RADIUS_W-1:0] radius_q;
	logic [vrpc_pkg::RSQ_W-1:0] rsq_q;

	logic signed [COORD_BITS-1:0] pt_x_q, pt_y_q, pt_z_q;
	logic [vrpc_pkg::TAG_W-1:0] pt_tag_q;

	logic [DW-1:0] amin_q, rmin_q;
	logic out_valid_q, out_inside_q;
	logic [vrpc_pkg::TAG_W-1:0] out_tag_q;

	logic in_fire;
	logic [vrpc_pkg::SLOT_W-1:0] in_slot;
	logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
	logic [CNT_W-1:0] n_a, n_r;
	logic idx_last;

	logic signed [COORD_BITS-1:0] ax [MAX_SITES];
	logic signed [COORD_BITS-1:0] ay [MAX_SITES];
	logic signed [COORD_BITS-1:0] az [MAX_SITES];
	logic signed [COORD_BITS-1:0] rx [MAX_SITES];
	logic signed [COORD_BITS-1:0] ry [MAX_SITES];
	logic signed [COORD_BITS-1:0] rz [MAX_SITES];

	logic signed [COORD_BITS-1:0] head_x, head_y, head_z;
	vrpc_pkg::dist_tag_t issue_tag, done_tag;
	logic [DW-1:0] dist_sq;
	logic [CMP_W-1:0] amin_ext, rsq_ext;
	logic in_region;
	logic out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign in_slot = s_axis_tdata[vrpc_pkg::SLOT_LSB +: vrpc_pkg::SLOT_W];
	assign in_x    = s_axis_tdata[vrpc_pkg::X_LSB +: COORD_BITS];
	assign in_y    = s_axis_tdata[vrpc_pkg::Y_LSB +: COORD_BITS];
	assign in_z    = s_axis_tdata[vrpc_pkg::Z_LSB +: COORD_BITS];

	always_comb begin
		if (attr_cnt_q == '0) begin
			n_a = CNT_W'(1);
		end else if (int'(attr_cnt_q) > MAX_SITES) begin
			n_a = CNT_W'(MAX_SITES);
		end else begin
			n_a = CNT_W'(attr_cnt_q);
		end
		if (rep_cnt_q == '0) begin
			n_r = CNT_W'(1);
		end else if (int'(rep_cnt_q) > MAX_SITES) begin
			n_r = CNT_W'(MAX_SITES);
		end else begin
			n_r = CNT_W'(rep_cnt_q);
		end
	end

	assign idx_last = (idx_q == CNT_W'(MAX_SITES - 1));

	// two rotating site chains, cell zero is the head
	for (genvar i = 0; i < MAX_SITES; i++) begin : g_chain
		vrpc_pkg::cell_ctrl_t actrl, rctrl;
		localparam int NXT = (i + 1) % MAX_SITES;

		assign actrl.load  = in_fire && (s_axis_tuser == vrpc_pkg::KIND_LOAD_ATTR)
			&& (int'(in_slot) == i);
		assign actrl.shift = (state_q == ST_RUN_A);
		assign rctrl.load  = in_fire && (s_axis_tuser == vrpc_pkg::KIND_LOAD_REP)
			&& (int'(in_slot) == i);
		assign rctrl.shift = (state_q == ST_RUN_R);

		vrpc_cell #(.COORD_BITS(COORD_BITS)) u_acell (
			.clk    (clk),
			.ctrl   (actrl),
			.load_x (in_x),
			.load_y (in_y),
			.load_z (in_z),
			.next_x (ax[NXT]),
			.next_y (ay[NXT]),
			.next_z (az[NXT]),
			.site_x (ax[i]),
			.site_y (ay[i]),
			.site_z (az[i])
		);

		vrpc_cell #(.COORD_BITS(COORD_BITS)) u_rcell (
			.clk    (clk),
			.ctrl   (rctrl),
			.load_x (in_x),
			.load_y (in_y),
			.load_z (in_z),
			.next_x (rx[NXT]),
			.next_y (ry[NXT]),
			.next_z (rz[NXT]),
			.site_x (rx[i]),
			.site_y (ry[i]),
			.site_z (rz[i])
		);
	end

	always_comb begin
		if (state_q == ST_RUN_R) begin
			head_x = rx[0];
			head_y = ry[0];
			head_z = rz[0];
			issue_tag.valid = (idx_q < n_r);
		end else begin
			head_x = ax[0];
			head_y = ay[0];
			head_z = az[0];
			issue_tag.valid = (state_q == ST_RUN_A) && (idx_q < n_a);
		end
		issue_tag.sel_rep = (state_q == ST_RUN_R);
		issue_tag.first   = (idx_q == '0);
	end

	vrpc_dist #(.COORD_BITS(COORD_BITS)) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (issue_tag),
		.site_x  (head_x),
		.site_y  (head_y),
		.site_z  (head_z),
		.pt_x    (pt_x_q),
		.pt_y    (pt_y_q),
		.pt_z    (pt_z_q),
		.tag_out (done_tag),
		.dist_sq (dist_sq)
	);

	// running minima
	always_ff @(posedge clk) begin
		if (done_tag.valid && !done_tag.sel_rep && (done_tag.first || dist_sq < amin_q)) begin
			amin_q <= dist_sq;
		end
		if (done_tag.valid && done_tag.sel_rep && (done_tag.first || dist_sq < rmin_q)) begin
			rmin_q <= dist_sq;
		end
	end

	assign amin_ext  = CMP_W'(amin_q);
	assign rsq_ext   = CMP_W'(rsq_q);
	assign in_region = (amin_q < rmin_q) && (!radius_mode_q || (amin_ext < rsq_ext));
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_cnt_q    <= vrpc_pkg::COUNT_W'(1);
			rep_cnt_q     <= vrpc_pkg::COUNT_W'(1);
			radius_mode_q <= 1'b0;
			radius_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vrpc_pkg::REG_ATTR_COUNT: begin
					attr_cnt_q <= cfg_data[vrpc_pkg::COUNT_W-1:0];
				end
				vrpc_pkg::REG_REP_COUNT: begin
					rep_cnt_q <= cfg_data[vrpc_pkg::COUNT_W-1:0];
				end
				vrpc_pkg::REG_RADIUS_MODE: begin
					radius_mode_q <= cfg_data[0];
				end
				vrpc_pkg::REG_RADIUS: begin
					radius_q <= cfg_data[vrpc_pkg::RADIUS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rsq_q <= vrpc_pkg::RSQ_W'(radius_q) * vrpc_pkg::RSQ_W'(radius_q);
		if (in_fire && (s_axis_tuser == vrpc_pkg::KIND_CLASSIFY)) begin
			pt_x_q   <= in_x;
			pt_y_q   <= in_y;
			pt_z_q   <= in_z;
			pt_tag_q <= s_axis_tdata[vrpc_pkg::TAG_LSB +: vrpc_pkg::TAG_W];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (s_axis_tuser == vrpc_pkg::KIND_CLASSIFY)) begin
						state_q <= ST_RUN_A;
						idx_q   <= '0;
					end
				end
				ST_RUN_A: begin
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_RUN_R;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_RUN_R: begin
					if (idx_last) begin
						idx_q   <= '0;
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_q == DRAIN_LAST) begin
						state_q <= ST_FIN;
					end else begin
						drain_q <= drain_q + 2'd1;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_inside_q <= in_region;
			out_tag_q    <= pt_tag_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = vrpc_pkg::OUT_DATA_W'({out_tag_q, out_inside_q});

endmodule

// ===== tb/sv/vrpc_result_checker.sv =====
`timescale 1ns / 1ps
// watches the classifier channels, predicts each classification and compares result beats
module vrpc_result_checker
	import vrpc_pkg::*;
#(
	parameter int SITES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [KIND_W-1:0]     s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending,
	output int                    results_seen,
	output int                    inside_seen
);

	typedef logic [2:0][FIELD_W-1:0] site_t;

	typedef struct packed {
		logic             in_region;
		logic [TAG_W-1:0] tag;
	} verdict_t;

	site_t              attr_sites[SITES];
	site_t              rep_sites[SITES];
	logic [COUNT_W-1:0] attr_count;
	logic [COUNT_W-1:0] rep_count;
	logic               radius_mode;
	logic [RADIUS_W-1:0] radius;
	verdict_t           verdicts_due[$];

	// exact squared distance, three 66-bit squares summed into 68 bits
	function automatic logic [67:0] dist_sq(input site_t a, input site_t b);
		logic signed [FIELD_W:0] d;
		logic [FIELD_W:0]        m;
		logic [65:0]             sq;
		logic [67:0]             acc;
		int                      k;
		acc = '0;
		for (k = 0; k < 3; k++) begin
			d = $signed({a[k][FIELD_W-1], a[k]}) - $signed({b[k][FIELD_W-1], b[k]});
			m = d[FIELD_W] ? (FIELD_W+1)'(-d) : (FIELD_W+1)'(d);
			sq = 66'(m) * 66'(m);
			acc = acc + 68'(sq);
		end
		return acc;
	endfunction

	function automatic logic [67:0] nearest(input bit from_rep, input site_t pt);
		int          n;
		int          i;
		logic [COUNT_W-1:0] count;
		logic [67:0] best;
		logic [67:0] d;
		count = from_rep ? rep_count : attr_count;
		n = (count == 0) ? 1 : ((count > SITES) ? SITES : int'(count));
		best = dist_sq(from_rep ? rep_sites[0] : attr_sites[0], pt);
		for (i = 1; i < n; i++) begin
			d = dist_sq(from_rep ? rep_sites[i] : attr_sites[i], pt);
			if (d < best)
				best = d;
		end
		return best;
	endfunction

	function automatic verdict_t classify_point(input site_t pt, input logic [TAG_W-1:0] tag);
		logic [67:0]      amin;
		logic [67:0]      rmin;
		logic [RSQ_W-1:0] rsq;
		verdict_t         v;
		amin = nearest(1'b0, pt);
		rmin = nearest(1'b1, pt);
		rsq = RSQ_W'(radius) * RSQ_W'(radius);
		v.in_region = (amin < rmin) && (!radius_mode || amin < 68'(rsq));
		v.tag = tag;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t got;
		verdict_t want;
		site_t    pt;
		int       fails;
		if (!arst_n) begin
			attr_count = 1;
			rep_count = 1;
			radius_mode = 1'b0;
			radius = '0;
			verdicts_due.delete();
			mismatches <= 0;
			pending <= 0;
			results_seen <= 0;
			inside_seen <= 0;
		end else begin
			fails = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				got.in_region = m_axis_tdata[0];
				got.tag = m_axis_tdata[TAG_W:1];
				results_seen <= results_seen + 1;
				inside_seen <= inside_seen + int'(got.in_region);
				if (verdicts_due.size() == 0) begin
					$error("result beat with no classification due: inside_res %0d result_tag %0d",
						got.in_region, got.tag);
					fails++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.in_region !== want.in_region) begin
						$error("inside_res mismatch: expected %0d, got %0d", want.in_region,
							got.in_region);
						fails++;
					end
					if (got.tag !== want.tag) begin
						$error("result_tag mismatch: expected %0d, got %0d", want.tag, got.tag);
						fails++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pt = s_axis_tdata[X_LSB +: 3*FIELD_W];
				case (s_axis_tuser)
					KIND_LOAD_ATTR: attr_sites[s_axis_tdata[SLOT_LSB +: SLOT_W]] = pt;
					KIND_LOAD_REP:  rep_sites[s_axis_tdata[SLOT_LSB +: SLOT_W]] = pt;
					KIND_CLASSIFY:  verdicts_due = {verdicts_due,
						classify_point(pt, s_axis_tdata[TAG_LSB +: TAG_W])};
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATTR_COUNT:  attr_count = cfg_data[COUNT_W-1:0];
					REG_REP_COUNT:   rep_count = cfg_data[COUNT_W-1:0];
					REG_RADIUS_MODE: radius_mode = cfg_data[0];
					REG_RADIUS:      radius = cfg_data[RADIUS_W-1:0];
					default: ;
				endcase
			end
			mismatches <= mismatches + fails;
			pending <= verdicts_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the voronoi region point classifier
module testbench;
	import vrpc_pkg::*;

	localparam int SITES       = 16;
	localparam int SETTLE      = 2 * SITES + 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 94;
	localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] P_MIN = 32'h8000_0000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [KIND_W-1:0]     s_axis_tuser = KIND_NONE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ATTR_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int pending;
	int results_seen;
	int inside_seen;
	int cycle_count = 0;
	int stall_left = 0;
	int items_sent = 0;
	int settings_run = 1;
	int attr_used = 1;
	int rep_used = 1;
	bit quiet = 1'b0;

	// stimulus-side copy of the loaded sites, used to aim points near them
	logic [2:0][31:0] attr_xyz[SITES];
	logic [2:0][31:0] rep_xyz[SITES];
	logic [SITES-1:0] attr_written = '0;
	logic [SITES-1:0] rep_written = '0;

	voronoi_region_point_classifier_unit #(
		.MAX_SITES(SITES),
		.COORD_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	vrpc_result_checker #(
		.SITES(SITES)
	) verdict_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.inside_seen(inside_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: random stall bursts between ready stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (m_axis_tready && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			m_axis_tready <= 1'b1;
			stall_left <= $urandom_range(0, 9);
		end
	end

	function automatic int sites_in_use(input int count);
		return (count == 0) ? 1 : ((count > SITES) ? SITES : count);
	endfunction

	function automatic logic [RADIUS_W-1:0] pick_radius();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return RADIUS_W'($urandom_range(0, 32'h0020_0000));
			default: return RADIUS_W'($urandom());
		endcase
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [3:0] slot,
		input logic [2:0][31:0] p, input logic [15:0] tag);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= IN_DATA_W'({tag, p, slot});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		if (kind == KIND_LOAD_ATTR) begin
			attr_xyz[slot] = p;
			attr_written[slot] = 1'b1;
		end else if (kind == KIND_LOAD_REP) begin
			rep_xyz[slot] = p;
			rep_written[slot] = 1'b1;
		end
	endtask

	// wait for every classification to come back, then let the pipeline settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_random(input logic [KIND_W-1:0] kind, input logic [3:0] slot);
		logic [2:0][31:0] p;
		int               axis;
		int               src;
		bit               copy_ok;
		src = $urandom_range(0, ((kind == KIND_LOAD_ATTR) ? rep_used : attr_used) - 1);
		copy_ok = (kind == KIND_LOAD_ATTR) ? rep_written[src] : attr_written[src];
		if (copy_ok && $urandom_range(0, 5) == 0) begin
			// copy a site of the other table to force ties
			p = (kind == KIND_LOAD_ATTR) ? rep_xyz[src] : attr_xyz[src];
		end else begin
			for (axis = 0; axis < 3; axis++)
				p[axis] = ($urandom_range(0, 3) == 0) ? $urandom()
					: $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		end
		send_item(kind, slot, p, 16'($urandom()));
	endtask

	task automatic classify_random();
		logic [2:0][31:0] p;
		logic [2:0][31:0] base;
		logic [31:0]      span;
		int               sel;
		int               axis;
		sel = $urandom_range(0, 7);
		base = ($urandom_range(0, 1) == 0) ? attr_xyz[$urandom_range(0, attr_used - 1)]
			: rep_xyz[$urandom_range(0, rep_used - 1)];
		for (axis = 0; axis < 3; axis++) begin
			span = 32'd1 << $urandom_range(0, 22);
			case (sel)
				0, 1: p[axis] = $urandom();
				2: p[axis] = base[axis];
				default: p[axis] = base[axis] + $urandom_range(0, 2 * span) - span;
			endcase
		end
		send_item(KIND_CLASSIFY, 4'($urandom()), p, 16'($urandom()));
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 15);
		if (r < 3)
			load_random(KIND_LOAD_ATTR, 4'($urandom()));
		else if (r < 6)
			load_random(KIND_LOAD_REP, 4'($urandom()));
		else if (r == 6)
			send_item(KIND_NONE, 4'($urandom()), {$urandom(), $urandom(), $urandom()},
				16'($urandom()));
		else
			classify_random();
	endtask

	// idle the block, write every register, then load any site now in use but never written
	task automatic reconfigure(input int a, input int r, input logic mode,
		input logic [RADIUS_W-1:0] rad);
		logic [CFG_IDX_W-1:0]  idx[4];
		logic [CFG_DATA_W-1:0] val[4];
		int                    i;
		drain();
		idx = '{REG_ATTR_COUNT, REG_REP_COUNT, REG_RADIUS_MODE, REG_RADIUS};
		val = '{CFG_DATA_W'(a), CFG_DATA_W'(r), CFG_DATA_W'(mode), CFG_DATA_W'(rad)};
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings_run++;
		attr_used = sites_in_use(a);
		rep_used = sites_in_use(r);
		for (i = 0; i < attr_used; i++)
			if (!attr_written[i])
				load_random(KIND_LOAD_ATTR, 4'(i));
		for (i = 0; i < rep_used; i++)
			if (!rep_written[i])
				load_random(KIND_LOAD_REP, 4'(i));
	endtask

	initial begin : limit_watch
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coordinate extremes with one site per table
		send_item(KIND_LOAD_ATTR, 4'd0, {P_MAX, P_MAX, P_MAX}, 16'h1234);
		send_item(KIND_LOAD_REP, 4'd0, {P_MIN, P_MIN, P_MIN}, 16'h0000);
		send_item(KIND_CLASSIFY, 4'd0, {P_MAX, P_MAX, P_MAX}, 16'hFFFF);
		send_item(KIND_CLASSIFY, 4'hF, {P_MIN, P_MIN, P_MIN}, 16'h0000);
		send_item(KIND_CLASSIFY, 4'd0, {32'd0, 32'd0, 32'd0}, 16'h0001);
		send_item(KIND_CLASSIFY, 4'd0, {32'd0, P_MAX, P_MIN}, 16'h8000);
		send_item(KIND_NONE, 4'hF, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 16'hFFFF);
		send_item(KIND_LOAD_REP, 4'hF, {P_MAX, P_MAX, P_MAX}, 16'h5555);
		send_item(KIND_LOAD_ATTR, 4'hF, {P_MIN, P_MIN, P_MIN}, 16'hAAAA);
		// same site in both tables: equal minima
		send_item(KIND_LOAD_REP, 4'd0, {P_MAX, P_MAX, P_MAX}, 16'h0000);
		send_item(KIND_CLASSIFY, 4'd0, {32'd3, 32'd2, 32'd1}, 16'h0002);
		send_item(KIND_CLASSIFY, 4'd0, {P_MAX, P_MAX, P_MAX}, 16'h0003);
		// point exactly halfway between the two sites
		send_item(KIND_LOAD_ATTR, 4'd0, {32'd0, 32'd0, 32'd0}, 16'h0000);
		send_item(KIND_LOAD_REP, 4'd0, {32'd0, 32'd0, 32'h0001_0000}, 16'h0000);
		send_item(KIND_CLASSIFY, 4'd0, {32'd0, 32'd0, 32'h0000_8000}, 16'h0004);
		send_item(KIND_CLASSIFY, 4'd0, {32'd0, 32'd0, 32'h0000_7FFF}, 16'h0005);

		// radius of one half: just inside, and exactly on the radius
		reconfigure(1, 1, 1'b1, RADIUS_W'(32'h0000_8000));
		send_item(KIND_CLASSIFY, 4'd0, {32'd0, 32'd0, 32'h0000_7FFF}, 16'h0006);
		send_item(KIND_CLASSIFY, 4'd0, {32'd0, 32'd0, 32'hFFFF_8000}, 16'h0007);
		send_item(KIND_CLASSIFY, 4'd0, {32'd0, 32'd0, 32'h0000_8000}, 16'h0008);

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: reconfigure(16, 16, 1'b1, '1);
				1: reconfigure(0, 31, 1'b1, '0);
				2: reconfigure(17, 0, 1'b0, pick_radius());
				default: reconfigure($urandom_range(0, 31), $urandom_range(0, 31),
					1'($urandom_range(0, 1)), pick_radius());
			endcase
			if (p == PHASES - 1)
				quiet <= 1'b1;
			repeat (PHASE_ITEMS) random_item();
		end
		drain();

		$display("sent %0d input beats under %0d register settings", items_sent, settings_run);
		$display("checked %0d classifications, %0d of them inside", results_seen, inside_seen);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
